FILE: rtl/fctv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctv_pkg
// Shared types and constants for the frame checksum and topic validator.
// ----------------------------------------------------------------------------
package fctv_pkg;

  localparam int MAX_FRAME   = 1023;
  localparam int TOPIC_SLOTS = 4;
  localparam int HEADER_LEN  = 26;
  localparam int SUM_FIRST   = 2;

  localparam int POS_W   = $clog2(MAX_FRAME + 1);
  localparam int DATA_W  = 8;
  localparam int TOPIC_W = 32;
  localparam int LEN_W   = 16;
  localparam int SUM_W   = 16;
  localparam int MASK_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NEED_W  = LEN_W + 1;

  // byte positions of the header fields
  localparam logic [POS_W-1:0] POS_CSUM_HI    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CSUM_LO    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TOPIC_FST  = POS_W'(18);
  localparam logic [POS_W-1:0] POS_TOPIC_LST  = POS_W'(21);
  localparam logic [POS_W-1:0] POS_LEN_HI     = POS_W'(24);
  localparam logic [POS_W-1:0] POS_LEN_LO     = POS_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_EN   = 3'd0,
    CFG_TOPIC_MASK = 3'd1,
    CFG_SLOT0      = 3'd2,
    CFG_SLOT1      = 3'd3,
    CFG_SLOT2      = 3'd4,
    CFG_SLOT3      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic check_en;
    logic topic_known;
  } cfg_status_t;

endpackage

FILE: rtl/fctv_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctv_in_if
// Byte channel into the validator: valid/ready plus one frame byte.
// ----------------------------------------------------------------------------
interface fctv_in_if
  import fctv_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              frame_start;
  logic              frame_end;

  modport source (output valid, data_byte, frame_start, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_start, frame_end, output ready);
endinterface

FILE: rtl/fctv_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctv_out_if
// Verdict channel out of the validator: valid/ready plus one frame verdict.
// ----------------------------------------------------------------------------
interface fctv_out_if
  import fctv_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               checksum_ok;
  logic               topic_known;
  logic               truncated;
  logic               length_too_long;
  logic [TOPIC_W-1:0] frame_topic;
  logic [LEN_W-1:0]   data_length;
  logic [SUM_W-1:0]   computed_sum;
  logic [SUM_W-1:0]   received_sum;

  modport source (output valid, accepted, checksum_ok, topic_known, truncated,
                  length_too_long, frame_topic, data_length, computed_sum,
                  received_sum, input ready);
  modport sink   (input valid, accepted, checksum_ok, topic_known, truncated,
                  length_too_long, frame_topic, data_length, computed_sum,
                  received_sum, output ready);
endinterface

FILE: rtl/fctv_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctv_cfg_regs
// Configuration registers and the topic slot match.
// ----------------------------------------------------------------------------
module fctv_cfg_regs
  import fctv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [TOPIC_W-1:0]    topic,
  output cfg_status_t           status
);

  logic                check_en_r;
  logic [MASK_W-1:0]   mask_r;
  logic [TOPIC_W-1:0]  slot_r [TOPIC_SLOTS];
  logic [CFG_IDX_W-1:0] slot_off;
  logic [1:0]          slot_sel;
  logic                known;

  assign slot_off = cfg_index - CFG_SLOT0;
  assign slot_sel = slot_off[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_en_r <= 1'b1;
      mask_r     <= '0;
      for (int i = 0; i < TOPIC_SLOTS; i++) begin
        slot_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_CHECK_EN:   check_en_r <= cfg_wdata[0];
        CFG_TOPIC_MASK: mask_r     <= cfg_wdata[MASK_W-1:0];
        CFG_SLOT0, CFG_SLOT1, CFG_SLOT2, CFG_SLOT3: begin
          for (int i = 0; i < TOPIC_SLOTS; i++) begin
            if (slot_sel == 2'(i)) begin
              slot_r[i] <= cfg_wdata[TOPIC_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    known = 1'b0;
    for (int i = 0; i < TOPIC_SLOTS; i++) begin
      if (mask_r[i] && (slot_r[i] == topic)) begin
        known = 1'b1;
      end
    end
  end

  assign status.check_en    = check_en_r;
  assign status.topic_known = known;

endmodule

FILE: rtl/frame_checksum_topic_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checksum_topic_validator
// Checks the rotate-and-add checksum, topic and length of a byte stream frame.
// The verdict is registered and appears in the cycle after the frame's last byte is taken.
// Throughput: one byte per cycle; the frame state registers and the verdict
// register are the only stages, so a new byte is taken whenever the verdict
// register is empty or being drained.
// Reset: synchronous, active low; clears frame state, config to defaults and
// the output valid.
// ----------------------------------------------------------------------------
module frame_checksum_topic_validator
  import fctv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  fctv_in_if.sink               in_ch,
  fctv_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [POS_W-1:0]   pos_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   carried_r;
  logic [TOPIC_W-1:0] topic_r;
  logic [LEN_W-1:0]   len_r;

  logic [POS_W-1:0]   pos_nxt;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SUM_W-1:0]   carried_nxt;
  logic [TOPIC_W-1:0] topic_nxt;
  logic [LEN_W-1:0]   len_nxt;

  logic [POS_W-1:0]   pos_cur;
  logic [NEED_W-1:0]  need;
  logic               in_fire;
  logic               out_valid_r;
  logic               sum_ok;
  logic               trunc;
  logic               too_long;
  cfg_status_t        status;

  logic               acc_r;
  logic               sum_ok_r;
  logic               known_r;
  logic               trunc_r;
  logic               too_long_r;
  logic [TOPIC_W-1:0] topic_out_r;
  logic [LEN_W-1:0]   len_out_r;
  logic [SUM_W-1:0]   sum_out_r;
  logic [SUM_W-1:0]   carried_out_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  fctv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .topic     (topic_nxt),
    .status    (status)
  );

  // frame state after this byte
  always_comb begin
    if (in_ch.frame_start) begin
      pos_cur     = '0;
      sum_nxt     = '0;
      carried_nxt = '0;
      topic_nxt   = '0;
      len_nxt     = '0;
    end else begin
      pos_cur     = pos_r;
      sum_nxt     = sum_r;
      carried_nxt = carried_r;
      topic_nxt   = topic_r;
      len_nxt     = len_r;
    end
    pos_nxt = pos_cur;
    if (pos_cur < POS_W'(MAX_FRAME)) begin
      case (pos_cur) inside
        POS_CSUM_HI: carried_nxt = {in_ch.data_byte, carried_nxt[7:0]};
        POS_CSUM_LO: carried_nxt = {carried_nxt[15:8], in_ch.data_byte};
        [POS_TOPIC_FST:POS_TOPIC_LST]: topic_nxt = {topic_nxt[23:0], in_ch.data_byte};
        POS_LEN_HI:  len_nxt = {in_ch.data_byte, len_nxt[7:0]};
        POS_LEN_LO:  len_nxt = {len_nxt[15:8], in_ch.data_byte};
        default: ;
      endcase
      if (pos_cur >= POS_W'(SUM_FIRST) &&
          NEED_W'(pos_cur) < (NEED_W'(len_nxt) + NEED_W'(HEADER_LEN))) begin
        sum_nxt = {sum_nxt[0], sum_nxt[SUM_W-1:1]} + SUM_W'(in_ch.data_byte);
      end
      pos_nxt = pos_cur + POS_W'(1);
    end
  end

  assign need     = NEED_W'(len_nxt) + NEED_W'(HEADER_LEN);
  assign trunc    = NEED_W'(pos_nxt) < need;
  assign too_long = len_nxt > LEN_W'(MAX_FRAME - HEADER_LEN);
  assign sum_ok   = sum_nxt == carried_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      sum_r     <= '0;
      carried_r <= '0;
      topic_r   <= '0;
      len_r     <= '0;
    end else if (in_fire) begin
      if (in_ch.frame_end) begin
        pos_r     <= '0;
        sum_r     <= '0;
        carried_r <= '0;
        topic_r   <= '0;
        len_r     <= '0;
      end else begin
        pos_r     <= pos_nxt;
        sum_r     <= sum_nxt;
        carried_r <= carried_nxt;
        topic_r   <= topic_nxt;
        len_r     <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_ch.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.frame_end) begin
      acc_r         <= !trunc && !too_long && (sum_ok || !status.check_en) &&
                       status.topic_known;
      sum_ok_r      <= sum_ok;
      known_r       <= status.topic_known;
      trunc_r       <= trunc;
      too_long_r    <= too_long;
      topic_out_r   <= topic_nxt;
      len_out_r     <= len_nxt;
      sum_out_r     <= sum_nxt;
      carried_out_r <= carried_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = acc_r;
  assign out_ch.checksum_ok     = sum_ok_r;
  assign out_ch.topic_known     = known_r;
  assign out_ch.truncated       = trunc_r;
  assign out_ch.length_too_long = too_long_r;
  assign out_ch.frame_topic     = topic_out_r;
  assign out_ch.data_length     = len_out_r;
  assign out_ch.computed_sum    = sum_out_r;
  assign out_ch.received_sum    = carried_out_r;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame checksum and topic validator. Frames
// built with known checksums, topics and lengths (plus broken and cut-short
// frames and loose byte noise) go in one byte per item under random idling
// on both sides. A bit-true frame tracker predicts each verdict, and every
// verdict taken at the output is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import fctv_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 70;
  localparam int RAND_PHASES  = 4;
  localparam int MIN_VERDICTS = 16;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_CAP    = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first;
    logic              last;
  } byte_item_t;

  typedef struct packed {
    logic               accepted;
    logic               checksum_ok;
    logic               topic_known;
    logic               truncated;
    logic               length_too_long;
    logic [TOPIC_W-1:0] frame_topic;
    logic [LEN_W-1:0]   data_length;
    logic [SUM_W-1:0]   computed_sum;
    logic [SUM_W-1:0]   received_sum;
  } verdict_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  drv_valid = 1'b0;
  logic [DATA_W-1:0]     drv_data  = '0;
  logic                  drv_first = 1'b0;
  logic                  drv_last  = 1'b0;
  logic                  rcv_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  fctv_in_if  in_if ();
  fctv_out_if out_if ();

  assign in_if.valid       = drv_valid;
  assign in_if.data_byte   = drv_data;
  assign in_if.frame_start = drv_first;
  assign in_if.frame_end   = drv_last;
  assign out_if.ready      = rcv_ready;

  frame_checksum_topic_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // config shadow
  logic               chk_en = 1'b1;
  logic [MASK_W-1:0]  topic_mask = '0;
  logic [TOPIC_W-1:0] topic_slot [4] = '{default: '0};

  // frame tracker
  int unsigned        fr_pos = 0;
  logic [SUM_W-1:0]   fr_sum = '0;
  logic [SUM_W-1:0]   fr_rx_sum = '0;
  logic [TOPIC_W-1:0] fr_topic = '0;
  logic [LEN_W-1:0]   fr_len = '0;

  byte_item_t  pending_bytes [$];
  verdict_t    verdict_q [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned items_queued = 0;
  int unsigned ends_queued = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          force_start = 1'b0;

  function automatic logic [SUM_W-1:0] rotate_add(logic [SUM_W-1:0] s, logic [DATA_W-1:0] b);
    return {s[0], s[SUM_W-1:1]} + SUM_W'(b);
  endfunction

  function automatic void clear_frame();
    fr_pos    = 0;
    fr_sum    = '0;
    fr_rx_sum = '0;
    fr_topic  = '0;
    fr_len    = '0;
  endfunction

  function automatic logic slot_hit(logic [TOPIC_W-1:0] t);
    for (int i = 0; i < TOPIC_SLOTS && i < 4; i++) begin
      if (topic_mask[i] && topic_slot[i] == t) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_byte(byte_item_t it);
    verdict_t    v;
    int unsigned need;
    if (it.first) clear_frame();
    if (fr_pos < MAX_FRAME) begin
      if (fr_pos == POS_CSUM_HI) fr_rx_sum[15:8] = it.data_byte;
      else if (fr_pos == POS_CSUM_LO) fr_rx_sum[7:0] = it.data_byte;
      else if (fr_pos >= POS_TOPIC_FST && fr_pos <= POS_TOPIC_LST)
        fr_topic = {fr_topic[TOPIC_W-9:0], it.data_byte};
      else if (fr_pos == POS_LEN_HI) fr_len[15:8] = it.data_byte;
      else if (fr_pos == POS_LEN_LO) fr_len[7:0] = it.data_byte;
      if (fr_pos >= SUM_FIRST && (fr_pos < HEADER_LEN || fr_pos < HEADER_LEN + fr_len))
        fr_sum = rotate_add(fr_sum, it.data_byte);
      fr_pos++;
    end
    if (it.last) begin
      need              = HEADER_LEN + fr_len;
      v.truncated       = fr_pos < need;
      v.length_too_long = fr_len > MAX_FRAME - HEADER_LEN;
      v.checksum_ok     = fr_sum == fr_rx_sum;
      v.topic_known     = slot_hit(fr_topic);
      v.accepted        = !v.truncated && !v.length_too_long &&
                          (v.checksum_ok || !chk_en) && v.topic_known;
      v.frame_topic     = fr_topic;
      v.data_length     = fr_len;
      v.computed_sum    = fr_sum;
      v.received_sum    = fr_rx_sum;
      verdict_q.push_back(v);
      clear_frame();
    end
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CHECK_EN:   chk_en = val[0];
      CFG_TOPIC_MASK: topic_mask = val[MASK_W-1:0];
      CFG_SLOT0:      topic_slot[0] = val;
      CFG_SLOT1:      topic_slot[1] = val;
      CFG_SLOT2:      topic_slot[2] = val;
      CFG_SLOT3:      topic_slot[3] = val;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < PRINT_CAP) $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("verdict %0d %s got %0h want %0h",
                                verdicts_seen, name, got, want));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_config(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(logic [DATA_W-1:0] b, logic s, logic e);
    byte_item_t it;
    it.data_byte = b;
    it.first     = s;
    it.last      = e;
    pending_bytes.push_back(it);
    items_queued++;
    if (e) ends_queued++;
  endtask

  task automatic queue_frame(bit with_start, bit with_end, int unsigned dlen,
                             int unsigned nbytes, bit bad_sum, logic [TOPIC_W-1:0] topic);
    logic [DATA_W-1:0] body [$];
    logic [SUM_W-1:0]  s;
    s = '0;
    for (int unsigned i = 0; i < nbytes; i++) body.push_back(DATA_W'($urandom));
    for (int unsigned i = 0; i < 4; i++) begin
      if (POS_TOPIC_FST + i < nbytes) body[POS_TOPIC_FST + i] = topic[31 - 8*i -: 8];
    end
    if (POS_LEN_HI < nbytes) body[POS_LEN_HI] = dlen[15:8];
    if (POS_LEN_LO < nbytes) body[POS_LEN_LO] = dlen[7:0];
    for (int unsigned i = SUM_FIRST; i < nbytes && i < MAX_FRAME && i < HEADER_LEN + dlen; i++)
      s = rotate_add(s, body[i]);
    if (nbytes > 0) body[0] = s[15:8];
    if (nbytes > 1) begin
      body[1] = s[7:0];
      if (bad_sum) body[1] = body[1] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int unsigned i = 0; i < nbytes; i++)
      push_item(body[i], with_start && i == 0, with_end && i == nbytes - 1);
  endtask

  function automatic logic [TOPIC_W-1:0] pick_topic();
    if ($urandom_range(0, 9) < 7) return topic_slot[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic queue_random_frame();
    int unsigned roll, dlen, n;
    bit          st;
    roll = $urandom_range(0, 99);
    st   = force_start || ($urandom_range(0, 9) != 0);
    force_start = 1'b0;
    dlen = pick_len();
    if (roll < 50) begin
      n = HEADER_LEN + dlen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      queue_frame(st, 1'b1, dlen, n, 1'b0, pick_topic());
    end else if (roll < 60) begin
      queue_frame(st, 1'b1, dlen, HEADER_LEN + dlen, 1'b1, pick_topic());
    end else if (roll < 72) begin
      queue_frame(st, 1'b1, dlen, $urandom_range(1, HEADER_LEN + dlen - 1), 1'b0, pick_topic());
    end else if (roll < 80) begin
      case ($urandom_range(0, 3))
        0:       dlen = MAX_FRAME - HEADER_LEN + 1;
        1:       dlen = 16'hFFFF;
        default: dlen = $urandom_range(MAX_FRAME - HEADER_LEN + 1, 16'hFFFF);
      endcase
      queue_frame(st, 1'b1, dlen, $urandom_range(HEADER_LEN, 60), 1'b0, pick_topic());
    end else if (roll < 88) begin
      // frame cut off by a fresh start mark
      queue_frame(st, 1'b0, dlen, $urandom_range(1, 40), 1'b0, pick_topic());
      force_start = 1'b1;
    end else begin
      n = $urandom_range(1, 8);
      for (int unsigned i = 0; i < n; i++)
        push_item(DATA_W'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic logic [TOPIC_W-1:0] pick_slot_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || drv_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    byte_item_t it;
    logic       next_valid;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        it = pending_bytes.pop_front();
        take_byte(it);
        bytes_taken++;
      end
      next_valid = 1'b0;
      if (drv_valid && !in_if.ready) begin
        next_valid = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (hold_left == 0 && $urandom_range(0, 99) < send_idle_pct) begin
        gap_left = $urandom_range(1, 13) - 1;
      end else if (pending_bytes.size() != 0) begin
        next_valid = 1'b1;
        it = pending_bytes[0];
        drv_data  <= it.data_byte;
        drv_first <= it.first;
        drv_last  <= it.last;
      end
      drv_valid <= next_valid;
    end
  end

  // output ready, with one long hold-off so the block backs up
  always @(posedge clk) begin
    logic r;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else begin
      r = 1'b0;
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && bytes_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if ($urandom_range(0, 99) < rcv_idle_pct) begin
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        r = 1'b1;
      end
      rcv_ready <= r;
    end
  end

  // verdict monitor
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with no frame end pending");
      end else begin
        want = verdict_q.pop_front();
        check_field("accepted",        32'(out_if.accepted),        32'(want.accepted));
        check_field("checksum_ok",     32'(out_if.checksum_ok),     32'(want.checksum_ok));
        check_field("topic_known",     32'(out_if.topic_known),     32'(want.topic_known));
        check_field("truncated",       32'(out_if.truncated),       32'(want.truncated));
        check_field("length_too_long", 32'(out_if.length_too_long),
                    32'(want.length_too_long));
        check_field("frame_topic",     out_if.frame_topic,          want.frame_topic);
        check_field("data_length",     32'(out_if.data_length),     32'(want.data_length));
        check_field("computed_sum",    32'(out_if.computed_sum),    32'(want.computed_sum));
        check_field("received_sum",    32'(out_if.received_sum),    32'(want.received_sum));
      end
      verdicts_seen++;
    end
  end

  initial begin
    int unsigned target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: odd short frames
    send_idle_pct = 20;
    rcv_idle_pct  = 20;
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h80, 1'b0, 1'b1);
    push_item(8'h12, 1'b1, 1'b0);
    push_item(8'h34, 1'b0, 1'b0);
    push_item(8'hA5, 1'b1, 1'b1);
    push_item(8'h5A, 1'b0, 1'b1);
    wait_idle();

    // every register, extreme slot values, largest frames
    write_reg(CFG_CHECK_EN,   CFG_DATA_W'({$urandom, 1'b1}));
    write_reg(CFG_TOPIC_MASK, CFG_DATA_W'({$urandom, 4'hF}));
    write_reg(CFG_SLOT0,      '0);
    write_reg(CFG_SLOT1,      '1);
    write_reg(CFG_SLOT2,      $urandom);
    write_reg(CFG_SLOT3,      $urandom);
    write_reg(CFG_SPARE_LO,   $urandom);
    write_reg(CFG_SPARE_HI,   $urandom);
    end_writes();
    queue_frame(1'b1, 1'b1, 0, HEADER_LEN, 1'b0, '0);
    queue_frame(1'b1, 1'b1, 0, HEADER_LEN + 1, 1'b0, '1);
    queue_frame(1'b1, 1'b1, 3, HEADER_LEN + 3, 1'b1, topic_slot[2]);
    queue_frame(1'b1, 1'b1, MAX_FRAME - HEADER_LEN, MAX_FRAME + 1, 1'b0, topic_slot[3]);
    queue_frame(1'b1, 1'b1, MAX_FRAME - HEADER_LEN + 1, HEADER_LEN + 4, 1'b0, '0);
    queue_frame(1'b1, 1'b1, 16'hFFFF, HEADER_LEN + 4, 1'b0, '1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_CHECK_EN,   CFG_DATA_W'({$urandom, ph == 0 ? 1'b0 : 1'($urandom)}));
      write_reg(CFG_TOPIC_MASK, CFG_DATA_W'({$urandom, ph == 0 ? 4'hF : ph == 1 ? 4'h0
                                             : 4'($urandom_range(0, 15))}));
      write_reg(CFG_SLOT0, pick_slot_value());
      write_reg(CFG_SLOT1, pick_slot_value());
      write_reg(CFG_SLOT2, pick_slot_value());
      write_reg(CFG_SLOT3, pick_slot_value());
      if (ph == 3) write_reg(CFG_SPARE_HI, $urandom);
      end_writes();
      if (ph == RAND_PHASES - 1) begin
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
      end else if (ph % 3 == 1) begin
        send_idle_pct = 0;
        rcv_idle_pct  = $urandom_range(5, 30);
      end else begin
        send_idle_pct = $urandom_range(5, 30);
        rcv_idle_pct  = $urandom_range(5, 30);
      end
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target ||
             (ph == RAND_PHASES - 1 && ends_queued < MIN_VERDICTS))
        queue_random_frame();
    end

    while (pending_bytes.size() != 0 || drv_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
